// ===== rtl/core/i2cmrt_pkg.sv =====
// Package for the I2C master register transfer block.
// Holds request codes, transfer stage codes and the front-to-back queue entry type.
// No dependencies.
package i2cmrt_pkg;

   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;
   localparam logic [1:0] REQ_LOAD  = 2'd3;

   localparam logic [2:0] STG_NONE  = 3'd0;
   localparam logic [2:0] STG_WADDR = 3'd1;
   localparam logic [2:0] STG_REG   = 3'd2;
   localparam logic [2:0] STG_RADDR = 3'd3;
   localparam logic [2:0] STG_DATA  = 3'd4;

   localparam logic [15:0] PHASE_TICKS_RESET = 16'd800;

   // One classified transaction passed from the front part to the back part.
   typedef struct packed {
      logic       tick;
      logic [1:0] kind;
      logic [7:0] device_addr;
      logic [7:0] reg_addr;
      logic [7:0] xfer_len;
      logic [7:0] write_byte;
      logic       sda_in;
   } item_type;

   // One result transaction.
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_enable;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic       rx_last;
      logic       done_res;
      logic       success;
      logic [2:0] fail_stage;
      logic       busy_res;
   } result_type;

endpackage

// ===== rtl/core/i2cmrt_queue.sv =====
// Short queue between the front part and the bus engine.
// Depends on i2cmrt_pkg.
module i2cmrt_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_valid,
   output logic                  wr_ready,
   input  i2cmrt_pkg::item_type  wr_item,
   output logic                  rd_valid,
   input  logic                  rd_ready,
   output i2cmrt_pkg::item_type  rd_item
);
   import i2cmrt_pkg::*;

   item_type   slot_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_item  = slot_ff[rptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= wr_item;
      end
   end

endmodule

// ===== rtl/core/i2cmrt_engine.sv =====
// Bus engine: phase divider, bit sequencer and write buffer; one result per item.
// Depends on i2cmrt_pkg.
module i2cmrt_engine #(
   parameter int WRITE_DEPTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [15:0]             csr_write_data,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  i2cmrt_pkg::item_type    in_item,
   output logic                    out_valid,
   input  logic                    out_ready,
   output i2cmrt_pkg::result_type  out_res
);
   import i2cmrt_pkg::*;

   localparam int AW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
   localparam int CW = $clog2(WRITE_DEPTH + 1);

   typedef enum logic [3:0] {
      PH_IDLE, PH_START_A, PH_START_B, PH_RS_LOW, PH_TX_LO, PH_TX_HI,
      PH_TACK_LO, PH_TACK_HI, PH_RX_LO, PH_RX_HI, PH_MACK_LO, PH_MACK_HI,
      PH_STOP_A, PH_STOP_B, PH_STOP_C
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] bit_ff, bit_in;
   logic [7:0] byte_ff, byte_in;
   logic [7:0] shift_ff, shift_in;
   logic [15:0] timer_ff, timer_in;
   logic [15:0] ticks_ff;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] addr_ff, addr_in, reg_ff, reg_in, len_ff, len_in;
   logic [CW-1:0] loaded_ff, loaded_in;
   logic [2:0] stage_ff, stage_in, failc_ff, failc_in;
   logic [7:0] wbuf [WRITE_DEPTH];
   logic       wbuf_we;
   result_type res_ff, res_in;
   logic       ovalid_ff;
   logic       step;
   logic [15:0] ticks_eff;
   logic       phase_end;
   logic [8:0] byte_p1;
   logic [8:0] wlen;

   assign in_ready  = !ovalid_ff || out_ready;
   assign out_valid = ovalid_ff;
   assign out_res   = res_ff;
   assign step      = in_valid && in_ready;
   assign ticks_eff = (ticks_ff == 16'd0) ? 16'd1 : ticks_ff;
   assign phase_end = ({1'b0, timer_ff} + 17'd1) >= {1'b0, ticks_eff};
   assign byte_p1   = {1'b0, byte_ff} + 9'd1;
   assign wlen      = ({1'b0, in_item.xfer_len} < 9'(loaded_ff))
                      ? {1'b0, in_item.xfer_len} : 9'(loaded_ff);

   always_comb begin
      phase_in  = phase_ff;  bit_in   = bit_ff;   byte_in  = byte_ff;
      shift_in  = shift_ff;  timer_in = timer_ff; kind_in  = kind_ff;
      addr_in   = addr_ff;   reg_in   = reg_ff;   len_in   = len_ff;
      loaded_in = loaded_ff; stage_in = stage_ff; failc_in = failc_ff;
      wbuf_we   = 1'b0;
      res_in    = '0;
      res_in.scl_level = 1'b1; res_in.sda_level = 1'b1;
      res_in.sda_enable = 1'b1; res_in.busy_res = 1'b1;
      if (phase_ff == PH_IDLE) begin
         res_in.busy_res = 1'b0;
         if (in_item.kind == REQ_READ || in_item.kind == REQ_WRITE) begin
            kind_in = in_item.kind;
            addr_in = in_item.device_addr;
            reg_in  = in_item.reg_addr;
            if (in_item.kind == REQ_READ) begin
               len_in = in_item.xfer_len;
            end else begin
               len_in    = wlen[7:0];
               loaded_in = '0;
            end
            stage_in = STG_NONE; byte_in = '0; bit_in = '0;
            failc_in = STG_NONE; timer_in = '0;
            phase_in = PH_START_A;
            res_in.busy_res = 1'b1;
         end else if (in_item.kind == REQ_LOAD && 32'(loaded_ff) < WRITE_DEPTH) begin
            wbuf_we   = 1'b1;
            loaded_in = loaded_ff + 1'b1;
         end
      end else begin
         unique case (phase_ff)
            PH_START_B: res_in.sda_level = 1'b0;
            PH_RS_LOW:  res_in.scl_level = 1'b0;
            PH_TX_LO: begin
               res_in.scl_level = 1'b0; res_in.sda_level = shift_ff[7];
            end
            PH_TX_HI:   res_in.sda_level = shift_ff[7];
            PH_TACK_LO, PH_RX_LO: begin
               res_in.scl_level = 1'b0; res_in.sda_enable = 1'b0;
            end
            PH_TACK_HI, PH_RX_HI: res_in.sda_enable = 1'b0;
            PH_MACK_LO, PH_MACK_HI: begin
               res_in.scl_level = (phase_ff == PH_MACK_HI);
               res_in.sda_level = byte_p1 >= 9'(len_ff);
            end
            PH_STOP_A: begin
               res_in.scl_level = 1'b0; res_in.sda_level = 1'b0;
            end
            PH_STOP_B:  res_in.sda_level = 1'b0;
            default: ;
         endcase
         if (!phase_end) begin
            timer_in = timer_ff + 16'd1;
         end else begin
            timer_in = '0;
            unique case (phase_ff)
               PH_START_A: phase_in = PH_START_B;
               PH_START_B: begin
                  bit_in = '0; phase_in = PH_TX_LO;
                  if (stage_ff == STG_REG) begin
                     shift_in = addr_ff | 8'h01; stage_in = STG_RADDR;
                  end else begin
                     shift_in = addr_ff & 8'hFE; stage_in = STG_WADDR;
                  end
               end
               PH_RS_LOW: phase_in = PH_START_A;
               PH_TX_LO:  phase_in = PH_TX_HI;
               PH_TX_HI: begin
                  shift_in = {shift_ff[6:0], 1'b0};
                  bit_in   = bit_ff + 4'd1;
                  phase_in = (bit_in >= 4'd8) ? PH_TACK_LO : PH_TX_LO;
               end
               PH_TACK_LO: phase_in = PH_TACK_HI;
               PH_TACK_HI: begin
                  if (in_item.sda_in) begin
                     failc_in = stage_ff; phase_in = PH_STOP_A;
                  end else if (stage_ff == STG_WADDR) begin
                     shift_in = reg_ff; bit_in = '0; stage_in = STG_REG;
                     phase_in = PH_TX_LO;
                  end else if (stage_ff == STG_REG) begin
                     if (kind_ff == REQ_READ) begin
                        phase_in = PH_RS_LOW;
                     end else begin
                        byte_in = '0;
                        if (len_ff != 8'd0) begin
                           shift_in = wbuf[0]; bit_in = '0;
                           stage_in = STG_DATA; phase_in = PH_TX_LO;
                        end else begin
                           failc_in = STG_NONE; phase_in = PH_STOP_A;
                        end
                     end
                  end else if (stage_ff == STG_RADDR) begin
                     byte_in = '0;
                     if (len_ff == 8'd0) begin
                        failc_in = STG_NONE; phase_in = PH_STOP_A;
                     end else begin
                        shift_in = '0; bit_in = '0; phase_in = PH_RX_LO;
                     end
                  end else begin
                     // Advance to the next buffered byte, read one ahead.
                     byte_in = byte_p1[7:0];
                     if ((byte_p1 < 9'(len_ff)) && (32'(byte_p1) < WRITE_DEPTH)) begin
                        shift_in = wbuf[byte_p1[AW-1:0]]; bit_in = '0;
                        stage_in = STG_DATA; phase_in = PH_TX_LO;
                     end else begin
                        failc_in = STG_NONE; phase_in = PH_STOP_A;
                     end
                  end
               end
               PH_RX_LO: phase_in = PH_RX_HI;
               PH_RX_HI: begin
                  shift_in = {shift_ff[6:0], in_item.sda_in};
                  bit_in   = bit_ff + 4'd1;
                  if (bit_in >= 4'd8) begin
                     res_in.rx_valid = 1'b1;
                     res_in.rx_data  = shift_in;
                     res_in.rx_last  = byte_p1 >= 9'(len_ff);
                     phase_in = PH_MACK_LO;
                  end else begin
                     phase_in = PH_RX_LO;
                  end
               end
               PH_MACK_LO: phase_in = PH_MACK_HI;
               PH_MACK_HI: begin
                  byte_in = byte_p1[7:0];
                  if (byte_p1 >= 9'(len_ff)) begin
                     failc_in = STG_NONE; phase_in = PH_STOP_A;
                  end else begin
                     shift_in = '0; bit_in = '0; phase_in = PH_RX_LO;
                  end
               end
               PH_STOP_A: phase_in = PH_STOP_B;
               PH_STOP_B: phase_in = PH_STOP_C;
               default: begin
                  res_in.done_res   = 1'b1;
                  res_in.success    = (failc_ff == STG_NONE);
                  res_in.fail_stage = failc_ff;
                  res_in.busy_res   = 1'b0;
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         bit_ff    <= '0;
         byte_ff   <= '0;
         shift_ff  <= '0;
         timer_ff  <= '0;
         kind_ff   <= '0;
         addr_ff   <= '0;
         reg_ff    <= '0;
         len_ff    <= '0;
         loaded_ff <= '0;
         stage_ff  <= STG_NONE;
         failc_ff  <= STG_NONE;
         ovalid_ff <= 1'b0;
         ticks_ff  <= PHASE_TICKS_RESET;
      end else begin
         if (csr_write_enable) begin
            ticks_ff <= csr_write_data;
         end
         if (step) begin
            phase_ff  <= phase_in;
            bit_ff    <= bit_in;
            byte_ff   <= byte_in;
            shift_ff  <= shift_in;
            timer_ff  <= timer_in;
            kind_ff   <= kind_in;
            addr_ff   <= addr_in;
            reg_ff    <= reg_in;
            len_ff    <= len_in;
            loaded_ff <= loaded_in;
            stage_ff  <= stage_in;
            failc_ff  <= failc_in;
            ovalid_ff <= 1'b1;
         end else if (out_ready) begin
            ovalid_ff <= 1'b0;
         end
      end
      if (step) begin
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && wbuf_we) begin
         wbuf[loaded_ff[AW-1:0]] <= in_item.write_byte;
      end
   end

endmodule

// ===== rtl/core/i2c_master_register_transfer_top.sv =====
// Top level of the I2C master register transfer block.
// Depends on i2cmrt_pkg, i2cmrt_queue and i2cmrt_engine.
//
// Channel  Direction  Handshake              Contents
// req_     in         req_valid/req_ready    request or tick transaction
// rsp_     out        rsp_valid/rsp_ready    bus levels, received byte, status
// csr_     in         csr_write_enable       phase_ticks, no wait
//
// One transaction per clock is sustained while the response side keeps up; each
// request transaction yields one response, which passes through the two-entry
// queue and the registered response stage.
// Reset is synchronous and active high; phase_ticks returns to 800.
// A stalled response side fills the queue, after which req_ready drops.
// The write buffer holds undefined data after reset until it is loaded.
module i2c_master_register_transfer_top #(
   parameter int WRITE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_device_addr,
   input  logic [7:0]  req_reg_addr,
   input  logic [7:0]  req_xfer_len,
   input  logic [7:0]  req_write_byte,
   input  logic        req_sda_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_level,
   output logic        rsp_sda_level,
   output logic        rsp_sda_enable,
   output logic        rsp_rx_valid,
   output logic [7:0]  rsp_rx_data,
   output logic        rsp_rx_last,
   output logic        rsp_done_res,
   output logic        rsp_success,
   output logic [2:0]  rsp_fail_stage,
   output logic        rsp_busy_res
);
   import i2cmrt_pkg::*;

   item_type   front_item, back_item;
   logic       back_valid, back_ready;
   result_type res;

   // The front part classifies the transaction: a plain tick is marked so.
   always_comb begin
      front_item.tick        = (req_type == REQ_TICK);
      front_item.kind        = req_type;
      front_item.device_addr = req_device_addr;
      front_item.reg_addr    = req_reg_addr;
      front_item.xfer_len    = req_xfer_len;
      front_item.write_byte  = req_write_byte;
      front_item.sda_in      = req_sda_in;
   end

   i2cmrt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_valid),
      .wr_ready (req_ready),
      .wr_item  (front_item),
      .rd_valid (back_valid),
      .rd_ready (back_ready),
      .rd_item  (back_item)
   );

   i2cmrt_engine #(.WRITE_DEPTH(WRITE_DEPTH)) u_engine (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .in_valid         (back_valid),
      .in_ready         (back_ready),
      .in_item          (back_item),
      .out_valid        (rsp_valid),
      .out_ready        (rsp_ready),
      .out_res          (res)
   );

   assign rsp_scl_level  = res.scl_level;
   assign rsp_sda_level  = res.sda_level;
   assign rsp_sda_enable = res.sda_enable;
   assign rsp_rx_valid   = res.rx_valid;
   assign rsp_rx_data    = res.rx_data;
   assign rsp_rx_last    = res.rx_last;
   assign rsp_done_res   = res.done_res;
   assign rsp_success    = res.success;
   assign rsp_fail_stage = res.fail_stage;
   assign rsp_busy_res   = res.busy_res;

   // Status fields only accompany a completed stop.
   a_done_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> !rsp_success && rsp_fail_stage == STG_NONE)
      else $error("status without completed stop");

   // A successful transfer reports no failing stage.
   a_success_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_success |-> rsp_fail_stage == STG_NONE)
      else $error("success with a failing stage");

   // A finished transfer leaves the engine idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done while still busy");

   // Received bytes only appear while SCL is high on the released line.
   a_rx_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rx_valid |-> rsp_scl_level && !rsp_sda_enable)
      else $error("received byte outside a read phase");

endmodule

// ===== tb/i2cmrt_checker.sv =====
// Checker for the I2C master register transfer block: watches both channels
// and the CSR port, predicts every response and compares it field by field.
// Depends on i2cmrt_pkg for request codes, stage codes and the result type.
module i2cmrt_checker
   import i2cmrt_pkg::*;
#(
   parameter int WRITE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_device_addr,
   input  logic [7:0]  req_reg_addr,
   input  logic [7:0]  req_xfer_len,
   input  logic [7:0]  req_write_byte,
   input  logic        req_sda_in,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  result_type  rsp_seen,
   output int          mismatch_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [4:0] {
      BP_IDLE, BP_START_A, BP_START_B, BP_RS_LOW, BP_TX_LO, BP_TX_HI,
      BP_TACK_LO, BP_TACK_HI, BP_RX_LO, BP_RX_HI, BP_MACK_LO, BP_MACK_HI,
      BP_STOP_A, BP_STOP_B, BP_STOP_C
   } bus_phase_e;

   bus_phase_e  bus_phase;
   logic [15:0] phase_ticks;
   logic [15:0] phase_timer;
   logic [3:0]  bit_count;
   logic [7:0]  byte_count;
   logic [7:0]  shift_reg;
   logic [1:0]  held_kind;
   logic [7:0]  held_addr;
   logic [7:0]  held_reg;
   logic [7:0]  held_len;
   logic [7:0]  write_buffer [WRITE_DEPTH];
   logic [4:0]  loaded_count;
   logic [2:0]  xfer_stage;
   logic [2:0]  fail_code;
   result_type  expected_rsp [$];

   assign pending_count = expected_rsp.size();

   task automatic begin_byte(input logic [7:0] value, input logic [2:0] stage);
      shift_reg  = value;
      bit_count  = 0;
      xfer_stage = stage;
      bus_phase  = BP_TX_LO;
   endtask

   task automatic go_stop(input logic [2:0] code);
      fail_code = code;
      bus_phase = BP_STOP_A;
   endtask

   task automatic next_write_byte();
      if (byte_count < held_len && byte_count < WRITE_DEPTH)
         begin_byte(write_buffer[byte_count], STG_DATA);
      else
         go_stop(STG_NONE);
   endtask

   // Advances the bus engine by one tick and returns the response it shows.
   task automatic predict_bus_tick(input logic [1:0] kind, input logic [7:0] dev,
                                   input logic [7:0] regb, input logic [7:0] len,
                                   input logic [7:0] wbyte, input logic sda,
                                   output result_type r);
      logic [16:0] ticks;
      logic        last_byte;
      r = '0;
      r.scl_level  = 1'b1;
      r.sda_level  = 1'b1;
      r.sda_enable = 1'b1;
      r.busy_res   = 1'b1;
      ticks = (phase_ticks == 0) ? 17'd1 : {1'b0, phase_ticks};
      last_byte = ({1'b0, byte_count} + 9'd1) >= {1'b0, held_len};
      if (bus_phase == BP_IDLE) begin
         r.busy_res = 1'b0;
         if (kind == REQ_READ || kind == REQ_WRITE) begin
            held_kind = kind;
            held_addr = dev;
            held_reg  = regb;
            if (kind == REQ_READ) begin
               held_len = len;
            end else begin
               held_len = (len < loaded_count) ? len : {3'b0, loaded_count};
               loaded_count = 0;
            end
            xfer_stage  = STG_NONE;
            byte_count  = 0;
            bit_count   = 0;
            fail_code   = STG_NONE;
            phase_timer = 0;
            bus_phase   = BP_START_A;
            r.busy_res  = 1'b1;
         end else if (kind == REQ_LOAD && loaded_count < WRITE_DEPTH) begin
            write_buffer[loaded_count] = wbyte;
            loaded_count++;
         end
      end else begin
         case (bus_phase)
            BP_START_B: r.sda_level = 1'b0;
            BP_RS_LOW:  r.scl_level = 1'b0;
            BP_TX_LO: begin
               r.scl_level = 1'b0;
               r.sda_level = shift_reg[7];
            end
            BP_TX_HI:   r.sda_level = shift_reg[7];
            BP_TACK_LO, BP_RX_LO: begin
               r.scl_level  = 1'b0;
               r.sda_enable = 1'b0;
            end
            BP_TACK_HI, BP_RX_HI: r.sda_enable = 1'b0;
            BP_MACK_LO, BP_MACK_HI: begin
               r.scl_level = (bus_phase == BP_MACK_HI);
               r.sda_level = last_byte;
            end
            BP_STOP_A: begin
               r.scl_level = 1'b0;
               r.sda_level = 1'b0;
            end
            BP_STOP_B:  r.sda_level = 1'b0;
            default: ;
         endcase
         if ({1'b0, phase_timer} + 17'd1 < ticks) begin
            phase_timer++;
         end else begin
            phase_timer = 0;
            case (bus_phase)
               BP_START_A: bus_phase = BP_START_B;
               BP_START_B: begin
                  if (xfer_stage == STG_REG)
                     begin_byte(held_addr | 8'h01, STG_RADDR);
                  else
                     begin_byte(held_addr & 8'hFE, STG_WADDR);
               end
               BP_RS_LOW:  bus_phase = BP_START_A;
               BP_TX_LO:   bus_phase = BP_TX_HI;
               BP_TX_HI: begin
                  shift_reg = shift_reg << 1;
                  bit_count++;
                  bus_phase = (bit_count >= 8) ? BP_TACK_LO : BP_TX_LO;
               end
               BP_TACK_LO: bus_phase = BP_TACK_HI;
               BP_TACK_HI: begin
                  if (sda) begin
                     go_stop(xfer_stage);
                  end else if (xfer_stage == STG_WADDR) begin
                     begin_byte(held_reg, STG_REG);
                  end else if (xfer_stage == STG_REG) begin
                     if (held_kind == REQ_READ) begin
                        bus_phase = BP_RS_LOW;
                     end else begin
                        byte_count = 0;
                        next_write_byte();
                     end
                  end else if (xfer_stage == STG_RADDR) begin
                     byte_count = 0;
                     if (held_len == 0) begin
                        go_stop(STG_NONE);
                     end else begin
                        shift_reg = 0;
                        bit_count = 0;
                        bus_phase = BP_RX_LO;
                     end
                  end else begin
                     byte_count++;
                     next_write_byte();
                  end
               end
               BP_RX_LO:   bus_phase = BP_RX_HI;
               BP_RX_HI: begin
                  shift_reg = {shift_reg[6:0], sda};
                  bit_count++;
                  if (bit_count >= 8) begin
                     r.rx_valid = 1'b1;
                     r.rx_data  = shift_reg;
                     r.rx_last  = last_byte;
                     bus_phase  = BP_MACK_LO;
                  end else begin
                     bus_phase = BP_RX_LO;
                  end
               end
               BP_MACK_LO: bus_phase = BP_MACK_HI;
               BP_MACK_HI: begin
                  byte_count++;
                  if (byte_count >= held_len) begin
                     go_stop(STG_NONE);
                  end else begin
                     shift_reg = 0;
                     bit_count = 0;
                     bus_phase = BP_RX_LO;
                  end
               end
               BP_STOP_A:  bus_phase = BP_STOP_B;
               BP_STOP_B:  bus_phase = BP_STOP_C;
               default: begin
                  r.done_res   = 1'b1;
                  r.success    = (fail_code == STG_NONE);
                  r.fail_stage = fail_code;
                  r.busy_res   = 1'b0;
                  bus_phase    = BP_IDLE;
               end
            endcase
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         bus_phase      = BP_IDLE;
         phase_ticks    = PHASE_TICKS_RESET;
         phase_timer    = 0;
         bit_count      = 0;
         byte_count     = 0;
         shift_reg      = 0;
         held_kind      = REQ_TICK;
         held_addr      = 0;
         held_reg       = 0;
         held_len       = 0;
         loaded_count   = 0;
         xfer_stage     = STG_NONE;
         fail_code      = STG_NONE;
         mismatch_count = 0;
         expected_rsp.delete();
      end else begin
         if (csr_write_enable)
            phase_ticks = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $error("response transaction with no expectation waiting");
               mismatch_count++;
            end else begin
               want = expected_rsp.pop_front();
               compare_field("scl_level",  want.scl_level,  rsp_seen.scl_level);
               compare_field("sda_level",  want.sda_level,  rsp_seen.sda_level);
               compare_field("sda_enable", want.sda_enable, rsp_seen.sda_enable);
               compare_field("rx_valid",   want.rx_valid,   rsp_seen.rx_valid);
               compare_field("rx_data",    want.rx_data,    rsp_seen.rx_data);
               compare_field("rx_last",    want.rx_last,    rsp_seen.rx_last);
               compare_field("done_res",   want.done_res,   rsp_seen.done_res);
               compare_field("success",    want.success,    rsp_seen.success);
               compare_field("fail_stage", want.fail_stage, rsp_seen.fail_stage);
               compare_field("busy_res",   want.busy_res,   rsp_seen.busy_res);
            end
         end
         if (req_valid && req_ready) begin
            predict_bus_tick(req_type, req_device_addr, req_reg_addr, req_xfer_len,
                             req_write_byte, req_sda_in, want);
            expected_rsp.push_back(want);
         end
      end
   end

endmodule

// ===== tb/tb_top.sv =====
// Top of the testbench for the I2C master register transfer block.
// Drives requests, CSR writes and response back-pressure; depends on
// i2cmrt_pkg, i2cmrt_checker and the block under test.
module tb_top;
   import i2cmrt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int RANDOM_ITEMS = 1000;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_type;
   logic [7:0]  req_device_addr;
   logic [7:0]  req_reg_addr;
   logic [7:0]  req_xfer_len;
   logic [7:0]  req_write_byte;
   logic        req_sda_in;
   logic        rsp_valid;
   logic        rsp_ready;
   result_type  rsp_seen;
   int          mismatch_count;
   int          pending_count;

   // Bookkeeping shared by the sender, the receiver and the verdict.
   int   sent_count;
   int   received_count;
   int   cycle_count;
   int   transfers_seen;
   logic last_busy;
   bit   steady_send;
   bit   steady_take;
   bit   hold_off_due;

   i2c_master_register_transfer_top uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_device_addr  (req_device_addr),
      .req_reg_addr     (req_reg_addr),
      .req_xfer_len     (req_xfer_len),
      .req_write_byte   (req_write_byte),
      .req_sda_in       (req_sda_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_scl_level    (rsp_seen.scl_level),
      .rsp_sda_level    (rsp_seen.sda_level),
      .rsp_sda_enable   (rsp_seen.sda_enable),
      .rsp_rx_valid     (rsp_seen.rx_valid),
      .rsp_rx_data      (rsp_seen.rx_data),
      .rsp_rx_last      (rsp_seen.rx_last),
      .rsp_done_res     (rsp_seen.done_res),
      .rsp_success      (rsp_seen.success),
      .rsp_fail_stage   (rsp_seen.fail_stage),
      .rsp_busy_res     (rsp_seen.busy_res)
   );

   i2cmrt_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_device_addr  (req_device_addr),
      .req_reg_addr     (req_reg_addr),
      .req_xfer_len     (req_xfer_len),
      .req_write_byte   (req_write_byte),
      .req_sda_in       (req_sda_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_seen         (rsp_seen),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A plain cycle counter guards against a hung handshake.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   // The receiver draws a random stall before every response transaction, unless
   // it is in a steady stretch. Once, on request, it holds off for a long stall
   // so that the queue fills and req_ready drops.
   initial begin
      int stall;
      rsp_ready      = 1'b0;
      received_count = 0;
      transfers_seen = 0;
      last_busy      = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = steady_take ? 0 : $urandom_range(0, 8);
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            stall = 400;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
         received_count++;
         last_busy = rsp_seen.busy_res;
         if (rsp_seen.done_res)
            transfers_seen++;
         if ($urandom_range(0, 199) == 0)
            steady_take = !steady_take;
      end
   end

   // Offers one request transaction after a random gap and waits for its
   // acceptance. Valid is raised only once the gap has passed, so it is never
   // lowered and raised again within the same edge.
   task automatic send_item(input logic [1:0] kind, input logic [7:0] dev,
                            input logic [7:0] regb, input logic [7:0] len,
                            input logic [7:0] wbyte, input logic sda);
      int gap;
      gap = steady_send ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_device_addr <= dev;
      req_reg_addr    <= regb;
      req_xfer_len    <= len;
      req_write_byte  <= wbyte;
      req_sda_in      <= sda;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      sent_count++;
   endtask

   // Sends clock ticks with a fixed SDA level until the bus engine reports
   // idle and every response has come back.
   task automatic run_to_idle(input logic sda);
      do begin
         send_item(REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   sda);
         req_valid <= 1'b0;
         while (received_count != sent_count) @(posedge clock);
      end while (last_busy);
   endtask

   // The block is idle here; a short wait covers its response pipeline before
   // the phase length is changed.
   task automatic set_phase_ticks(input logic [15:0] value);
      repeat (8) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Draws one random request transaction. Slave SDA is mostly low so that most
   // bytes are acknowledged and transfers run deep; the occasional high bit
   // gives NACKs at every stage and ones in the received data. Read lengths
   // stay short so that read transfers end soon.
   task automatic send_random(input bit with_transfers);
      int   pick;
      logic [1:0] kind;
      logic [7:0] len;
      pick = $urandom_range(0, 99);
      if (!with_transfers)
         kind = (pick < 70) ? REQ_TICK : REQ_LOAD;
      else if (pick < 70)
         kind = REQ_TICK;
      else if (pick < 82)
         kind = REQ_LOAD;
      else if (pick < 91)
         kind = REQ_READ;
      else
         kind = REQ_WRITE;
      len = 8'($urandom_range(0, 5));
      if (kind == REQ_WRITE && $urandom_range(0, 3) == 0)
         len = 8'($urandom_range(0, 255));
      send_item(kind, 8'($urandom), 8'($urandom), len, 8'($urandom),
                $urandom_range(0, 99) < 12);
   endtask

   initial begin
      logic [15:0] settings [4];
      int i;
      int s;
      settings = '{16'd1, 16'd2, 16'd3, 16'd0};
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_type         = REQ_TICK;
      req_device_addr  = '0;
      req_reg_addr     = '0;
      req_xfer_len     = '0;
      req_write_byte   = '0;
      req_sda_in       = 1'b0;
      sent_count       = 0;
      steady_send      = 1'b0;
      steady_take      = 1'b0;
      hold_off_due     = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset phase length: idle ticks and loads only,
      // since a transfer at 800 ticks per phase would be very slow.
      send_item(REQ_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_item(REQ_LOAD, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0);
      send_item(REQ_LOAD, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1);
      send_item(REQ_LOAD, 8'h5A, 8'hC3, 8'h01, 8'hA5, 1'b0);
      run_to_idle(1'b0);
      set_phase_ticks(16'd1);

      // A write capped to the three loaded bytes, fully acknowledged.
      send_item(REQ_WRITE, 8'hA1, 8'h3C, 8'hFF, 8'h00, 1'b0);
      run_to_idle(1'b0);
      // A zero-length read, then a one-byte read of all ones after the ACKs
      // have passed is covered by the random part; here every bit reads low.
      send_item(REQ_READ, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      run_to_idle(1'b0);
      send_item(REQ_READ, 8'hFF, 8'hFF, 8'h01, 8'hFF, 1'b0);
      run_to_idle(1'b0);
      // A slave that never answers NACKs the write address.
      send_item(REQ_READ, 8'h42, 8'h10, 8'h02, 8'h00, 1'b1);
      run_to_idle(1'b1);
      // Seventeen loads: the last one finds the buffer full and is dropped.
      for (i = 0; i < 17; i++)
         send_item(REQ_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), 8'(i * 15), 1'b0);
      send_item(REQ_WRITE, 8'h3E, 8'h7F, 8'd20, 8'h00, 1'b0);
      // Requests while busy are ignored but still count as ticks.
      send_item(REQ_READ, 8'h11, 8'h22, 8'h03, 8'h00, 1'b0);
      send_item(REQ_LOAD, 8'h11, 8'h22, 8'h03, 8'h99, 1'b0);
      run_to_idle(1'b0);
      // A write with nothing loaded sends only address and register.
      send_item(REQ_WRITE, 8'h80, 8'h01, 8'h05, 8'h00, 1'b0);
      run_to_idle(1'b0);

      // Random part, one slice per phase length including zero, which the
      // block treats as one.
      for (s = 0; s < 4; s++) begin
         set_phase_ticks(settings[s]);
         for (i = 0; i < RANDOM_ITEMS / 4; i++) begin
            if (i % 100 == 0)
               steady_send = ($urandom_range(0, 2) == 0);
            if (s == 1 && i == 150)
               hold_off_due = 1'b1;
            send_random(1'b1);
         end
         steady_send = 1'b0;
         run_to_idle(1'b0);
      end

      // The slowest phase length: idle traffic and loads only.
      set_phase_ticks(16'hFFFF);
      for (i = 0; i < 60; i++)
         send_random(1'b0);
      run_to_idle(1'b0);
      set_phase_ticks(16'd1);

      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Covered %0d request transactions and %0d completed transfers", sent_count,
               transfers_seen);
      $display("over phase lengths 800, 1, 2, 3, 0 and 65535.");
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
